// ===== hdl/pba_pkg.sv =====
`default_nettype none

package pba_pkg;

    localparam int NUM_PAGES = 65536;
    localparam int WORD_BITS = 32;
    localparam int NUM_WORDS = NUM_PAGES / WORD_BITS;
    localparam int NUM_GROUPS = NUM_WORDS / WORD_BITS;
    localparam int WORD_AW = $clog2(NUM_WORDS);
    localparam int BIT_AW = $clog2(WORD_BITS);
    localparam int GROUP_AW = $clog2(NUM_GROUPS);
    localparam int PAGE_W = 16;
    localparam int COUNT_W = 17;
    localparam int ADDR_W = 32;
    localparam int SHIFT_W = 5;
    localparam int KIND_W = 3;
    localparam int STATUS_W = 2;
    localparam int PADDR_W = 3;

    typedef enum logic [KIND_W-1:0] {
        K_CLAIM    = 3'd0,
        K_UNCLAIM  = 3'd1,
        K_ALLOC_LO = 3'd2,
        K_ALLOC_HI = 3'd3,
        K_FREE     = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_NOFREE = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CNT_NONE,
        CNT_ADD,
        CNT_SUB
    } t_cnt_op;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RD,
        S_MOD,
        S_ASUM,
        S_AWORD,
        S_FINISH
    } t_state;

    // Register byte addresses
    localparam logic [PADDR_W-1:0] REG_PAGE_SHIFT = 3'd0;
    localparam logic [PADDR_W-1:0] REG_MEMORY_SIZE = 3'd4;

    function automatic logic [BIT_AW-1:0] low_zero_w(input logic [WORD_BITS-1:0] v);
        logic [BIT_AW-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!v[i]) idx = BIT_AW'(i);
        end
        return idx;
    endfunction

    function automatic logic [BIT_AW-1:0] high_zero_w(input logic [WORD_BITS-1:0] v);
        logic [BIT_AW-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (!v[i]) idx = BIT_AW'(i);
        end
        return idx;
    endfunction

    function automatic logic [GROUP_AW-1:0] low_zero_g(input logic [NUM_GROUPS-1:0] v);
        logic [GROUP_AW-1:0] idx;
        idx = '0;
        for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
            if (!v[i]) idx = GROUP_AW'(i);
        end
        return idx;
    endfunction

    function automatic logic [GROUP_AW-1:0] high_zero_g(input logic [NUM_GROUPS-1:0] v);
        logic [GROUP_AW-1:0] idx;
        idx = '0;
        for (int i = 0; i < NUM_GROUPS; i++) begin
            if (!v[i]) idx = GROUP_AW'(i);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/page_bitmap_allocator_unit.sv =====
// Bitmap page allocator: one used bit per page in a 2048 x 32 bitmap memory, a 64 x 32
// summary memory with one "word full" bit per bitmap word, and 64 group-full flags in
// flops. After reset the block runs a clearing pass over both memories and takes no
// item until it ends. Requests are handled one at a time. Claim, unclaim and free
// read, modify and write back each bitmap word they touch, one word after another,
// once the request is accepted and decoded. Both allocation kinds work in order:
// the group flags pick a group, the summary word picks a bitmap word, that word picks
// the page. Requests that change nothing go from decode straight to completion. A
// result waits in an output register while the next item is taken; a result still
// stalled when the next one completes holds the block until it leaves.
`default_nettype none

module page_bitmap_allocator_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // APB configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pba_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    // request stream
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] start_address, [63:32] end_address, [79:64] page_to_free
    input  wire logic [79:0]                 s_axis_tdata,
    // [2:0] kind
    input  wire logic [2:0]                  s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [15:0] allocated_page, [17:16] status, [34:18] used_pages, [39:35] zero
    output logic      [39:0]                 m_axis_tdata
);
    import pba_pkg::*;

    // memories
    logic [WORD_BITS-1:0] bm_mem  [NUM_WORDS];
    logic [WORD_BITS-1:0] sum_mem [NUM_GROUPS];
    logic [WORD_BITS-1:0] r_bm_rd;
    logic [WORD_BITS-1:0] r_sum_rd;

    logic                 bm_we, bm_re, sum_we, sum_re;
    logic [WORD_AW-1:0]   bm_waddr, bm_raddr;
    logic [GROUP_AW-1:0]  sum_waddr, sum_raddr;
    logic [WORD_BITS-1:0] bm_wdata, sum_wdata;

    // control and request registers
    t_state               r_state, n_state;
    logic [WORD_AW-1:0]   r_clr, n_clr;
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic [ADDR_W-1:0]    r_sa, n_sa;
    logic [ADDR_W-1:0]    r_ea, n_ea;
    logic [PAGE_W-1:0]    r_pf, n_pf;
    logic [PAGE_W-1:0]    r_sp, n_sp;
    logic [PAGE_W-1:0]    r_ep, n_ep;
    logic [WORD_AW-1:0]   r_word, n_word;
    logic [GROUP_AW-1:0]  r_group, n_group;
    logic [NUM_GROUPS-1:0] r_top, n_top;
    logic [COUNT_W-1:0]   r_count, n_count;
    t_cnt_op              r_cnt_op, n_cnt_op;
    logic [COUNT_W-1:0]   r_cnt_n, n_cnt_n;
    logic [PAGE_W-1:0]    r_res_page, n_res_page;
    logic [STATUS_W-1:0]  r_res_status, n_res_status;
    logic [SHIFT_W-1:0]   r_page_shift;
    logic [ADDR_W-1:0]    r_mem_size;
    logic                 r_out_valid, n_out_valid;
    logic [PAGE_W-1:0]    r_out_page, n_out_page;
    logic [STATUS_W-1:0]  r_out_status, n_out_status;
    logic [COUNT_W-1:0]   r_out_used, n_out_used;

    // datapath temporaries
    logic [ADDR_W-1:0]    sp_full, ep_full;
    logic [PAGE_W-1:0]    ep_clip;
    logic [BIT_AW-1:0]    lo, hi, idx;
    logic [WORD_BITS-1:0] mask, new_word, new_sum;
    logic [GROUP_AW-1:0]  grp;
    logic [COUNT_W-1:0]   room, cnt_next;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_MEMORY_SIZE) ? r_mem_size : {27'd0, r_page_shift};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_shift <= SHIFT_W'(12);
            r_mem_size   <= 32'h1000_0000;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr == REG_MEMORY_SIZE) begin
                r_mem_size <= pwdata;
            end else if (paddr == REG_PAGE_SHIFT) begin
                r_page_shift <= pwdata[SHIFT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        if (bm_re) begin
            r_bm_rd <= bm_mem[bm_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        if (sum_re) begin
            r_sum_rd <= sum_mem[sum_raddr];
        end
    end

    assign sp_full = r_sa >> r_page_shift;
    assign ep_full = r_ea >> r_page_shift;
    assign ep_clip = (ep_full > ADDR_W'(NUM_PAGES - 1)) ? PAGE_W'(NUM_PAGES - 1)
                                                        : ep_full[PAGE_W-1:0];

    // saturating counter update
    always_comb begin
        room = COUNT_W'(NUM_PAGES) - r_count;
        case (r_cnt_op)
            CNT_ADD: cnt_next = (r_cnt_n >= room) ? COUNT_W'(NUM_PAGES) : r_count + r_cnt_n;
            CNT_SUB: cnt_next = (r_cnt_n >= r_count) ? '0 : r_count - r_cnt_n;
            default: cnt_next = r_count;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_kind       = r_kind;
        n_sa         = r_sa;
        n_ea         = r_ea;
        n_pf         = r_pf;
        n_sp         = r_sp;
        n_ep         = r_ep;
        n_word       = r_word;
        n_group      = r_group;
        n_top        = r_top;
        n_count      = r_count;
        n_cnt_op     = r_cnt_op;
        n_cnt_n      = r_cnt_n;
        n_res_page   = r_res_page;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_page   = r_out_page;
        n_out_status = r_out_status;
        n_out_used   = r_out_used;
        bm_we        = 1'b0;
        bm_re        = 1'b0;
        sum_we       = 1'b0;
        sum_re       = 1'b0;
        bm_waddr     = r_word;
        bm_raddr     = r_word;
        bm_wdata     = '0;
        sum_waddr    = r_word[WORD_AW-1:BIT_AW];
        sum_raddr    = r_word[WORD_AW-1:BIT_AW];
        sum_wdata    = '0;
        lo           = '0;
        hi           = '1;
        idx          = '0;
        mask         = '0;
        new_word     = r_bm_rd;
        new_sum      = r_sum_rd;
        grp          = '0;
        s_axis_tready = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                bm_we     = 1'b1;
                bm_waddr  = r_clr;
                sum_we    = 1'b1;
                sum_waddr = r_clr[GROUP_AW-1:0];
                n_clr     = r_clr + 1'b1;
                if (r_clr == WORD_AW'(NUM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_kind       = s_axis_tuser;
                    n_sa         = s_axis_tdata[31:0];
                    n_ea         = s_axis_tdata[63:32];
                    n_pf         = s_axis_tdata[79:64];
                    n_res_status = ST_DONE;
                    n_res_page   = '0;
                    n_cnt_op     = CNT_NONE;
                    n_cnt_n      = '0;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_kind)
                    K_CLAIM, K_UNCLAIM: begin
                        if (r_ea > r_mem_size) begin
                            n_res_status = ST_RANGE;
                            n_state      = S_FINISH;
                        end else if (sp_full > ADDR_W'(ep_clip)) begin
                            n_state = S_FINISH;
                        end else begin
                            n_sp     = sp_full[PAGE_W-1:0];
                            n_ep     = ep_clip;
                            n_word   = sp_full[PAGE_W-1:BIT_AW];
                            n_cnt_op = (r_kind == K_CLAIM) ? CNT_ADD : CNT_SUB;
                            n_cnt_n  = COUNT_W'(ep_clip - sp_full[PAGE_W-1:0]);
                            n_state  = S_RD;
                        end
                    end
                    K_ALLOC_LO, K_ALLOC_HI: begin
                        if (&r_top) begin
                            n_res_status = ST_NOFREE;
                            n_state      = S_FINISH;
                        end else begin
                            grp       = (r_kind == K_ALLOC_LO) ? low_zero_g(r_top)
                                                               : high_zero_g(r_top);
                            n_group   = grp;
                            sum_re    = 1'b1;
                            sum_raddr = grp;
                            n_state   = S_ASUM;
                        end
                    end
                    K_FREE: begin
                        n_sp     = r_pf;
                        n_ep     = r_pf;
                        n_word   = r_pf[PAGE_W-1:BIT_AW];
                        n_cnt_op = CNT_SUB;
                        n_cnt_n  = COUNT_W'(1);
                        n_state  = S_RD;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_RD: begin
                bm_re   = 1'b1;
                sum_re  = 1'b1;
                n_state = S_MOD;
            end
            S_MOD: begin
                // bit span of this word inside the range
                if (r_word == r_sp[PAGE_W-1:BIT_AW]) lo = r_sp[BIT_AW-1:0];
                if (r_word == r_ep[PAGE_W-1:BIT_AW]) hi = r_ep[BIT_AW-1:0];
                mask = ({WORD_BITS{1'b1}} << lo)
                     & ({WORD_BITS{1'b1}} >> (BIT_AW'(WORD_BITS - 1) - hi));
                new_word = (r_kind == K_CLAIM) ? (r_bm_rd | mask) : (r_bm_rd & ~mask);
                new_sum[r_word[BIT_AW-1:0]] = &new_word;
                bm_we     = 1'b1;
                bm_wdata  = new_word;
                sum_we    = 1'b1;
                sum_wdata = new_sum;
                n_top[r_word[WORD_AW-1:BIT_AW]] = &new_sum;
                if (r_word == r_ep[PAGE_W-1:BIT_AW]) begin
                    n_state = S_FINISH;
                end else begin
                    n_word  = r_word + 1'b1;
                    n_state = S_RD;
                end
            end
            S_ASUM: begin
                idx      = (r_kind == K_ALLOC_LO) ? low_zero_w(r_sum_rd) : high_zero_w(r_sum_rd);
                n_word   = {r_group, idx};
                bm_re    = 1'b1;
                bm_raddr = {r_group, idx};
                n_state  = S_AWORD;
            end
            S_AWORD: begin
                idx      = (r_kind == K_ALLOC_LO) ? low_zero_w(r_bm_rd) : high_zero_w(r_bm_rd);
                new_word = r_bm_rd | (WORD_BITS'(1) << idx);
                new_sum[r_word[BIT_AW-1:0]] = &new_word;
                bm_we     = 1'b1;
                bm_wdata  = new_word;
                sum_we    = 1'b1;
                sum_waddr = r_group;
                sum_wdata = new_sum;
                n_top[r_group] = &new_sum;
                n_res_page = {r_word, idx};
                n_cnt_op   = CNT_ADD;
                n_cnt_n    = COUNT_W'(1);
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_count      = cnt_next;
                    n_out_valid  = 1'b1;
                    n_out_page   = r_res_page;
                    n_out_status = r_res_status;
                    n_out_used   = cnt_next;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_top       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cnt_op    <= CNT_NONE;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_top       <= n_top;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_cnt_op    <= n_cnt_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_sa         <= n_sa;
        r_ea         <= n_ea;
        r_pf         <= n_pf;
        r_sp         <= n_sp;
        r_ep         <= n_ep;
        r_word       <= n_word;
        r_group      <= n_group;
        r_cnt_n      <= n_cnt_n;
        r_res_page   <= n_res_page;
        r_res_status <= n_res_status;
        r_out_page   <= n_out_page;
        r_out_status <= n_out_status;
        r_out_used   <= n_out_used;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_used, r_out_status, r_out_page};

endmodule

`default_nettype wire

// ===== hdl/pba_chk.sv =====
`default_nettype none

module pba_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        pready,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    import pba_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while a request is in flight");

    // counter never passes the page count
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[34] && (m_axis_tdata[33:18] != '0)))
        else $error("used page count above page total");

    // a failed or ignored request grants page zero
    a_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[17:16] != ST_DONE) |-> m_axis_tdata[15:0] == '0)
        else $error("page granted with failing status");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind page_bitmap_allocator_unit pba_chk u_pba_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pba_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;
    localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_LAST = 3'd7;

    typedef struct {
        logic [PAGE_W-1:0]  page;
        t_status            status;
        logic [COUNT_W-1:0] used;
    } t_alloc_result;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic        s_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    // shadow copy of the page bitmap and configuration
    logic [WORD_BITS-1:0] page_map [NUM_WORDS];
    int unsigned          used_cnt;
    logic [SHIFT_W-1:0]   cfg_shift;
    logic [ADDR_W-1:0]    cfg_mem;
    int unsigned          last_granted;

    t_alloc_result pending_results [$];
    t_alloc_result want_res;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int mismatch_count = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_granted = 0;
    int n_refused = 0;
    int n_ignored = 0;

    page_bitmap_allocator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void count_up(int unsigned n);
        if (n >= NUM_PAGES - used_cnt) used_cnt = NUM_PAGES;
        else used_cnt += n;
    endfunction

    function automatic void count_down(int unsigned n);
        if (n >= used_cnt) used_cnt = 0;
        else used_cnt -= n;
    endfunction

    function automatic t_status mark_pages(logic [31:0] sa, logic [31:0] ea, bit used);
        int unsigned sp, ep;
        if (ea > cfg_mem) return ST_RANGE;
        sp = sa >> cfg_shift;
        ep = ea >> cfg_shift;
        // pages past the bitmap are dropped
        if (ep > NUM_PAGES - 1) ep = NUM_PAGES - 1;
        if (sp > ep) return ST_DONE;
        for (int unsigned p = sp; p <= ep; p++) page_map[p / WORD_BITS][p % WORD_BITS] = used;
        if (used) count_up(ep - sp);
        else count_down(ep - sp);
        return ST_DONE;
    endfunction

    function automatic bit find_free_page(bit from_top, output int unsigned page);
        int w, b;
        page = 0;
        for (int i = 0; i < NUM_WORDS; i++) begin
            w = from_top ? NUM_WORDS - 1 - i : i;
            if (page_map[w] != '1) begin
                for (int j = 0; j < WORD_BITS; j++) begin
                    b = from_top ? WORD_BITS - 1 - j : j;
                    if (!page_map[w][b]) begin
                        page = w * WORD_BITS + b;
                        return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic t_alloc_result predict_request(logic [2:0] kind, logic [31:0] sa,
                                                      logic [31:0] ea, logic [15:0] pf);
        t_alloc_result r;
        int unsigned pg;
        r.page = '0;
        r.status = ST_DONE;
        case (kind)
            K_CLAIM:   r.status = mark_pages(sa, ea, 1'b1);
            K_UNCLAIM: r.status = mark_pages(sa, ea, 1'b0);
            K_ALLOC_LO, K_ALLOC_HI: begin
                if (find_free_page(kind == K_ALLOC_HI, pg)) begin
                    page_map[pg / WORD_BITS][pg % WORD_BITS] = 1'b1;
                    count_up(1);
                    r.page = PAGE_W'(pg);
                    last_granted = pg;
                    n_granted++;
                end else begin
                    r.status = ST_NOFREE;
                    n_refused++;
                end
            end
            K_FREE: begin
                if (pf < NUM_PAGES) begin
                    page_map[pf / WORD_BITS][pf % WORD_BITS] = 1'b0;
                    count_down(1);
                end
            end
            default: ;
        endcase
        if (r.status == ST_RANGE) n_ignored++;
        r.used = COUNT_W'(used_cnt);
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(string what, logic [39:0] want, logic [39:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
    endtask

    always @(negedge i_clk) m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result", '0, m_axis_tdata);
            end else begin
                want_res = pending_results.pop_front();
                if (m_axis_tdata[15:0] !== want_res.page)
                    flag_mismatch("allocated_page", 40'(want_res.page), 40'(m_axis_tdata[15:0]));
                if (m_axis_tdata[17:16] !== want_res.status)
                    flag_mismatch("status", 40'(want_res.status), 40'(m_axis_tdata[17:16]));
                if (m_axis_tdata[34:18] !== want_res.used)
                    flag_mismatch("used_pages", 40'(want_res.used), 40'(m_axis_tdata[34:18]));
                if (m_axis_tdata[39:35] !== '0)
                    flag_mismatch("result padding", '0, 40'(m_axis_tdata[39:35]));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready) ||
                (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // ---------------------------------------------------------------- drivers

    task automatic apb_write_check(logic [PADDR_W-1:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // read the register back
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== data) flag_mismatch("register readback", 40'(data), 40'(prdata));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_config(logic [SHIFT_W-1:0] shift, logic [ADDR_W-1:0] mem);
        apb_write_check(REG_PAGE_SHIFT, 32'(shift));
        cfg_shift = shift;
        apb_write_check(REG_MEMORY_SIZE, mem);
        cfg_mem = mem;
    endtask

    task automatic send_req(logic [2:0] kind, logic [31:0] sa, logic [31:0] ea,
                            logic [15:0] pf);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {pf, ea, sa};
        s_tuser <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(predict_request(kind, sa, ea, pf));
        n_requests++;
    endtask

    // drop valid and wait for every outstanding result
    task automatic settle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_random_request();
        int unsigned pick, ep_hi, ep, sp, span;
        logic [63:0] wide;
        logic [31:0] lowmask, sa, ea;
        logic [15:0] pf;
        logic [2:0]  kind;
        pick = $urandom_range(0, 99);
        sa = $urandom;
        ea = $urandom;
        pf = 16'($urandom);
        lowmask = (32'd1 << cfg_shift) - 32'd1;
        ep_hi = cfg_mem >> cfg_shift;
        if (ep_hi > NUM_PAGES + 64) ep_hi = NUM_PAGES + 64;
        if (pick < 40) begin
            kind = $urandom_range(0, 1) ? K_UNCLAIM : K_CLAIM;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ep = $urandom_range(0, ep_hi);
                4, 5, 6, 7: ep = $urandom_range(0, (ep_hi < 2047) ? ep_hi : 2047);
                default:    ep = ep_hi - $urandom_range(0, (ep_hi < 2000) ? ep_hi : 2000);
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 80) span = $urandom_range(0, 40);
            else if (pick < 97) span = $urandom_range(0, 2000);
            else span = $urandom_range(0, NUM_PAGES - 1);
            sp = (span > ep) ? 0 : ep - span;
            if ($urandom_range(0, 19) == 0) sp = ep + $urandom_range(1, 50);
            wide = (64'(sp) << cfg_shift) | 64'($urandom & lowmask);
            sa = wide[31:0];
            wide = (64'(ep) << cfg_shift) | 64'($urandom & lowmask);
            ea = (wide > 64'(cfg_mem)) ? cfg_mem : wide[31:0];
            // one byte past the end of memory
            if ($urandom_range(0, 9) == 0 && cfg_mem != '1) ea = cfg_mem + 32'd1;
        end else if (pick < 70) begin
            kind = $urandom_range(0, 1) ? K_ALLOC_HI : K_ALLOC_LO;
        end else if (pick < 88) begin
            kind = K_FREE;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: pf = 16'(last_granted + $urandom_range(0, 80) - 40);
                4, 5, 6:    pf = 16'($urandom_range(0, 2047));
                default:    ;
            endcase
        end else if (pick < 90) begin
            // sweep all of memory
            kind = $urandom_range(0, 1) ? K_UNCLAIM : K_CLAIM;
            sa = $urandom & lowmask;
            ea = cfg_mem;
        end else if (pick < 95) begin
            kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
        end else begin
            kind = 3'($urandom);
        end
        send_req(kind, sa, ea, pf);
    endtask

    task automatic run_mix(int src, int snk, logic [SHIFT_W-1:0] shift_a,
                           logic [ADDR_W-1:0] mem_a, logic [SHIFT_W-1:0] shift_b,
                           logic [ADDR_W-1:0] mem_b, int n);
        src_idle_pct = src;
        snk_stall_pct = snk;
        load_config(shift_a, mem_a);
        repeat (n / 2) send_random_request();
        settle();
        load_config(shift_b, mem_b);
        repeat (n - n / 2) send_random_request();
        settle();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        send_req(K_ALLOC_LO, '1, '1, '1);
        send_req(K_ALLOC_HI, '0, '0, '0);
        send_req(K_FREE, '0, '0, 16'hFFFF);
        send_req(K_FREE, '0, '0, 16'd0);
        send_req(K_FREE, '0, '0, 16'd0);
        send_req(K_CLAIM, 32'h0, 32'h1FFF, '0);
        send_req(K_CLAIM, 32'h5000, 32'h1000, '0);
        send_req(K_CLAIM, 32'h0, 32'h1000_0001, '0);
        send_req(K_UNCLAIM, '1, '1, '0);
        send_req(K_CLAIM, 32'h0FFF_F000, 32'h1000_0000, '0);
        send_req(K_CLAIM, 32'h0, 32'h1000_0000, '0);
        send_req(K_ALLOC_LO, '0, '0, '0);
        send_req(K_ALLOC_HI, '0, '0, '0);
        send_req(K_FREE, '0, '0, 16'd1000);
        send_req(K_ALLOC_HI, '0, '0, '0);
        send_req(K_FREE, '0, '0, 16'd40000);
        send_req(K_ALLOC_LO, '0, '0, '0);
        send_req(K_UNCLAIM, 32'h0004_0000, 32'h0007_F000, '0);
        send_req(K_ALLOC_LO, '0, '0, '0);
        send_req(K_ALLOC_HI, '0, '0, '0);
        for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
            send_req(3'(k), $urandom, $urandom, 16'($urandom));
        send_req(K_UNCLAIM, 32'h0, 32'h0FFF_FFFF, '0);
        send_req(K_CLAIM, 32'h0, 32'h0, '0);
        settle();
    endtask

    task automatic test_back_to_back();
        run_mix(0, 0, 5'd12, 32'h1000_0000, 5'd30, 32'hFFFF_FFFF, 456);
    endtask

    task automatic test_sender_gaps();
        run_mix(70, 0, 5'd0, 32'hFFFF_FFFF, 5'd31, 32'h0, 456);
    endtask

    task automatic test_receiver_stalls();
        run_mix(0, 70, 5'd20, $urandom, 5'd5, 32'h0010_0000, 456);
    endtask

    task automatic test_mixed_idle();
        run_mix(17, 17, 5'd16, 32'h7FFF_FFFF, 5'd12, 32'h1000_0000, 457);
    endtask

    initial begin
        for (int w = 0; w < NUM_WORDS; w++) page_map[w] = '0;
        used_cnt = 0;
        last_granted = 0;
        cfg_shift = 5'd12;
        cfg_mem = 32'h1000_0000;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idle();

        repeat (50) @(posedge i_clk);
        $display("summary: %0d requests and %0d results over eight register settings",
                 n_requests, n_results);
        $display("summary: %0d pages granted, %0d allocations refused, %0d ranges outside memory",
                 n_granted, n_refused, n_ignored);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     pending_results.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== page_bitmap_allocator_unit.f =====
hdl/pba_pkg.sv
hdl/page_bitmap_allocator_unit.sv
hdl/pba_chk.sv
verif/tb.sv
